// ----- rtl/core/time_of_day_clock_three_alarms_defines.svh -----
// Assertion macros used by the time-of-day clock checker.
`ifndef TIME_OF_DAY_CLOCK_THREE_ALARMS_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_THREE_ALARMS_DEFINES_SVH

// Checked on clock, off while reset is high.
`define TODC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on clock at every edge, reset included.
`define TODC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/todc3a_pkg.sv -----
// Types and constants of the time-of-day clock with three alarms.
`timescale 1ns / 1ps

package todc3a_pkg;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // counter limits
   localparam logic [6:0] SECONDS_PER_MINUTE = 7'd60;
   localparam logic [6:0] MINUTES_PER_HOUR   = 7'd60;
   localparam logic [5:0] HOURS_PER_DAY      = 6'd24;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MORNING_HOUR     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MORNING_MINUTE   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AFTERNOON_HOUR   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AFTERNOON_MINUTE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EVENING_HOUR     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EVENING_MINUTE   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOT_DRAWER_IDS  = 3'd6;

   localparam int unsigned CSR_DATA_WIDTH = 24;

   // register reset values
   localparam logic [4:0]  RST_MORNING_HOUR     = 5'd7;
   localparam logic [5:0]  RST_MORNING_MINUTE   = 6'd0;
   localparam logic [4:0]  RST_AFTERNOON_HOUR   = 5'd12;
   localparam logic [5:0]  RST_AFTERNOON_MINUTE = 6'd0;
   localparam logic [4:0]  RST_EVENING_HOUR     = 5'd19;
   localparam logic [5:0]  RST_EVENING_MINUTE   = 6'd0;
   localparam logic [23:0] RST_SLOT_DRAWER_IDS  = 24'h020100;

   typedef struct packed {
      logic       operation;
      logic       hold_alarm;
      logic [4:0] load_hour;
      logic [5:0] load_minute;
      logic [5:0] load_second;
   } req_payload_type;

   typedef struct packed {
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [5:0] now_second;
      logic       alarm_active;
      logic [7:0] selected_drawer;
   } rsp_payload_type;

endpackage

// ----- rtl/core/time_of_day_clock_three_alarms.sv -----
// Top level: time-of-day clock with three daily alarms.
// Latency: a result appears in the cycle after its request transfer (one register stage).
// Throughput: one request per cycle while no result is stalled; the next-time and alarm logic is a single pass.
// Requests are taken while a result waits, as long as that result is being taken.
// Reset (synchronous, high): time 00:00:00, alarm off, drawer 0, alarm registers to defaults.
// No request is taken while reset is high.
`timescale 1ns / 1ps

module time_of_day_clock_three_alarms
   import todc3a_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_data,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_data,
   // register write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // ---------------------------------------------------------------
   // Alarm registers
   // ---------------------------------------------------------------
   logic [4:0]  morning_hour_ff;
   logic [5:0]  morning_minute_ff;
   logic [4:0]  afternoon_hour_ff;
   logic [5:0]  afternoon_minute_ff;
   logic [4:0]  evening_hour_ff;
   logic [5:0]  evening_minute_ff;
   logic [23:0] slot_drawer_ids_ff;

   // Every write is taken as it is offered, so the port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         morning_hour_ff     <= RST_MORNING_HOUR;
         morning_minute_ff   <= RST_MORNING_MINUTE;
         afternoon_hour_ff   <= RST_AFTERNOON_HOUR;
         afternoon_minute_ff <= RST_AFTERNOON_MINUTE;
         evening_hour_ff     <= RST_EVENING_HOUR;
         evening_minute_ff   <= RST_EVENING_MINUTE;
         slot_drawer_ids_ff  <= RST_SLOT_DRAWER_IDS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MORNING_HOUR:     morning_hour_ff     <= csr_data[4:0];
            REG_MORNING_MINUTE:   morning_minute_ff   <= csr_data[5:0];
            REG_AFTERNOON_HOUR:   afternoon_hour_ff   <= csr_data[4:0];
            REG_AFTERNOON_MINUTE: afternoon_minute_ff <= csr_data[5:0];
            REG_EVENING_HOUR:     evening_hour_ff     <= csr_data[4:0];
            REG_EVENING_MINUTE:   evening_minute_ff   <= csr_data[5:0];
            REG_SLOT_DRAWER_IDS:  slot_drawer_ids_ff  <= csr_data[23:0];
            default: ; // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------
   // The result register frees up in the same cycle its contents are
   // taken, so a request can follow every cycle without a bubble.
   logic req_xfer;
   logic rsp_valid_ff;

   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign req_xfer  = req_valid & ~req_stall;

   // ---------------------------------------------------------------
   // Time and alarm state
   // ---------------------------------------------------------------
   logic [5:0] clock_second_ff, clock_second_in;
   logic [5:0] clock_minute_ff, clock_minute_in;
   logic [4:0] clock_hour_ff,   clock_hour_in;
   logic       alarm_flag_ff,   alarm_flag_in;
   logic [7:0] drawer_latch_ff, drawer_latch_in;

   // Increments one bit wider so a loaded value above its limit
   // (e.g. second 63) still carries instead of wrapping first.
   logic [6:0] sec_inc;
   logic [6:0] min_inc;
   logic [5:0] hour_inc;
   logic       sec_carry;
   logic       min_carry;
   logic [5:0] tick_second;
   logic [5:0] tick_minute;
   logic [4:0] tick_hour;
   logic       hit_morning;
   logic       hit_afternoon;
   logic       hit_evening;

   assign sec_inc   = {1'b0, clock_second_ff} + 7'd1;
   assign min_inc   = {1'b0, clock_minute_ff} + 7'd1;
   assign hour_inc  = {1'b0, clock_hour_ff} + 6'd1;
   assign sec_carry = (sec_inc >= SECONDS_PER_MINUTE);
   assign min_carry = sec_carry & (min_inc >= MINUTES_PER_HOUR);

   always_comb begin
      tick_second = sec_carry ? 6'd0 : sec_inc[5:0];

      tick_minute = clock_minute_ff;
      if (sec_carry) begin
         tick_minute = (min_inc >= MINUTES_PER_HOUR) ? 6'd0 : min_inc[5:0];
      end

      tick_hour = clock_hour_ff;
      if (min_carry) begin
         tick_hour = (hour_inc >= HOURS_PER_DAY) ? 5'd0 : hour_inc[4:0];
      end
   end

   // Alarms compare against the time after the advance.
   assign hit_morning   = (tick_hour == morning_hour_ff)   && (tick_minute == morning_minute_ff);
   assign hit_afternoon = (tick_hour == afternoon_hour_ff) &&
                          (tick_minute == afternoon_minute_ff);
   assign hit_evening   = (tick_hour == evening_hour_ff)   && (tick_minute == evening_minute_ff);

   always_comb begin
      clock_second_in = clock_second_ff;
      clock_minute_in = clock_minute_ff;
      clock_hour_in   = clock_hour_ff;
      alarm_flag_in   = alarm_flag_ff;
      drawer_latch_in = drawer_latch_ff;

      case (req_data.operation)
         OP_LOAD: begin
            // Load sets the time only; alarm state is left alone.
            clock_second_in = req_data.load_second;
            clock_minute_in = req_data.load_minute;
            clock_hour_in   = req_data.load_hour;
         end
         OP_TICK: begin
            clock_second_in = tick_second;
            clock_minute_in = tick_minute;
            clock_hour_in   = tick_hour;
            // Priority: morning, afternoon, evening.
            if (hit_morning) begin
               alarm_flag_in   = 1'b1;
               drawer_latch_in = slot_drawer_ids_ff[7:0];
            end else if (hit_afternoon) begin
               alarm_flag_in   = 1'b1;
               drawer_latch_in = slot_drawer_ids_ff[15:8];
            end else if (hit_evening) begin
               alarm_flag_in   = 1'b1;
               drawer_latch_in = slot_drawer_ids_ff[23:16];
            end else if (!req_data.hold_alarm) begin
               alarm_flag_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_second_ff <= '0;
         clock_minute_ff <= '0;
         clock_hour_ff   <= '0;
         alarm_flag_ff   <= 1'b0;
         drawer_latch_ff <= '0;
      end else if (req_xfer) begin
         clock_second_ff <= clock_second_in;
         clock_minute_ff <= clock_minute_in;
         clock_hour_ff   <= clock_hour_in;
         alarm_flag_ff   <= alarm_flag_in;
         drawer_latch_ff <= drawer_latch_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   rsp_payload_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.now_hour        = clock_hour_in;
      rsp_data_in.now_minute      = clock_minute_in;
      rsp_data_in.now_second      = clock_second_in;
      rsp_data_in.alarm_active    = alarm_flag_in;
      rsp_data_in.selected_drawer = drawer_latch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset; it only loads on a request transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/todc3a_checker.sv -----
// Port-level checker for the time-of-day clock, with its bind.
`timescale 1ns / 1ps
`include "time_of_day_clock_three_alarms_defines.svh"

module todc3a_checker
   import todc3a_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   logic        req_xfer;
   logic        load_xfer;
   logic        rsp_held;
   logic [16:0] load_time;
   logic [16:0] shown_time;

   assign req_xfer   = req_valid && !req_stall;
   assign load_xfer  = req_xfer && (req_data.operation == OP_LOAD);
   assign rsp_held   = rsp_valid && rsp_stall;
   assign load_time  = {req_data.load_hour, req_data.load_minute, req_data.load_second};
   assign shown_time = {rsp_data.now_hour, rsp_data.now_minute, rsp_data.now_second};

   `TODC_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result valid after reset")

   `TODC_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_data), "stalled result moved")

   `TODC_ASSERT(a_req_gives_rsp, req_xfer |=> rsp_valid, "request transfer gave no result")

   `TODC_ASSERT(a_load_echo, load_xfer |=> shown_time == $past(load_time), "load not shown")

endmodule

bind time_of_day_clock_three_alarms todc3a_checker u_todc3a_checker (.*);
